// ===== hw/rtl/kcls_pkg.sv =====
// Shared types and constants for the keyframe curve sampler.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps

package kcls_pkg;

    // Item function codes
    typedef logic [1:0] t_func;
    localparam t_func FUNC_WRITE = 2'd0;
    localparam t_func FUNC_ONE   = 2'd1;
    localparam t_func FUNC_ALL   = 2'd2;
    localparam t_func FUNC_RSVD  = 2'd3;

    // Configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_FRAME_COUNT   = 2'd0;
    localparam t_cfg_idx CFG_CHANNEL_COUNT = 2'd1;
    localparam t_cfg_idx CFG_INV_DURATION  = 2'd2;

    // Fixed-point layout: normalized time is UQ1.40, clamped to one
    localparam int U_FRAC = 40;
    localparam int U_W    = U_FRAC + 1;
    localparam logic [U_W-1:0] U_ONE = {1'b1, {U_FRAC{1'b0}}};

    typedef logic signed [15:0] t_value;

endpackage

// ===== hw/rtl/keyframe_curve_lerp_sampler.sv =====
// Keyframe curve sampler: frame-major value store with linear interpolation.
// Depends on kcls_pkg.
`timescale 1ns / 1ps
// Write item: no result; one write per cycle sustained while o_stall is low.
// Sample item: S_MUL1, S_MUL2 and S_LOC locate the frame (two multiplies, one
//   split), then S_RD0, S_RD1, S_MULT and S_EMIT run per channel (two reads of
//   the store's single read port, one multiply, one output load). Invalid samples
//   skip S_RD1 and S_MULT. Sample-all runs the per-channel states for each channel.
// Reset clears control and configuration; the store is not cleared.

module keyframe_curve_lerp_sampler #(
    parameter int MAX_FRAMES   = 512,
    parameter int MAX_CHANNELS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  kcls_pkg::t_cfg_idx   i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    // input items
    input  logic                 i_valid,
    output logic                 o_stall,
    input  kcls_pkg::t_func      i_func,
    input  logic [8:0]           i_frame_index,
    input  logic [5:0]           i_channel_index,
    input  logic signed [15:0]   i_write_value,
    input  logic [31:0]          i_sample_time,
    // result items
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [5:0]           o_out_channel,
    output logic signed [15:0]   o_out_value,
    output logic                 o_out_valid,
    output logic                 o_out_last
);
    import kcls_pkg::*;

    localparam int STORE_DEPTH = MAX_FRAMES * MAX_CHANNELS;
    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int FW  = $clog2(MAX_FRAMES);
    localparam int FCW = $clog2(MAX_FRAMES + 1);
    localparam int CW  = $clog2(MAX_CHANNELS + 1);
    localparam int PW  = U_W + FCW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_LOC  = 3'd3;
    localparam logic [2:0] S_RD0  = 3'd4;
    localparam logic [2:0] S_RD1  = 3'd5;
    localparam logic [2:0] S_MULT = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    // configuration
    logic [9:0]  r_frame_count;
    logic [6:0]  r_channel_count;
    logic [31:0] r_inv_duration;

    // control
    logic [2:0]  r_state, n_state;
    logic [CW-1:0] r_cur;
    logic        r_ok;

    // item payload and datapath
    t_func       r_func;
    logic [5:0]  r_ch;
    logic [31:0] r_time;
    logic [U_W-1:0] r_u;
    logic [PW-1:0]  r_p;
    logic [FW-1:0]  r_f0, r_f1;
    logic [15:0]    r_alpha;
    logic [15:0]    r_v0;
    logic [15:0]    r_rdata;
    logic signed [33:0] r_prod;

    // output register
    logic        r_o_valid;
    logic [5:0]  r_o_channel;
    t_value      r_o_value;
    logic        r_o_out_valid;
    logic        r_o_last;

    // store
    logic [15:0] mem [0:STORE_DEPTH-1];

    logic          in_acc, out_acc, slot_free, wr_en, is_last, start;
    logic [FCW-1:0] nf, nfm1, f0_raw, f0_cl, f1_nx;
    logic [CW-1:0]  nc;
    logic [63:0]    u_full;
    logic [AW-1:0]  rd_addr, wr_addr;
    logic [31:0]    rd_chan;
    logic signed [16:0] diff;

    // Saturate the counts to the store size
    always_comb begin
        if (32'(r_frame_count) > MAX_FRAMES) begin
            nf = FCW'(MAX_FRAMES);
        end else begin
            nf = FCW'(r_frame_count);
        end
        if (32'(r_channel_count) > MAX_CHANNELS) begin
            nc = CW'(MAX_CHANNELS);
        end else begin
            nc = CW'(r_channel_count);
        end
        nfm1 = nf - FCW'(1);
    end

    assign in_acc    = i_valid && !o_stall;
    assign out_acc   = r_o_valid && !i_stall;
    assign slot_free = !r_o_valid || !i_stall;
    assign o_stall   = (r_state != S_IDLE);
    assign start     = (i_func == FUNC_ONE) || ((i_func == FUNC_ALL) && (nc != '0));
    assign is_last   = (r_func == FUNC_ONE) || ((32'(r_cur) + 32'd1) == 32'(nc));

    // Frame position split
    assign u_full = 64'(r_time) * 64'(r_inv_duration);
    assign f0_raw = r_p[U_FRAC +: FCW];
    assign f0_cl  = (f0_raw > nfm1) ? nfm1 : f0_raw;
    assign f1_nx  = ((f0_cl + FCW'(1)) < nf) ? (f0_cl + FCW'(1)) : nfm1;

    // Store addressing
    assign rd_chan = (r_func == FUNC_ONE) ? 32'(r_ch) : 32'(r_cur);
    assign rd_addr = (r_state == S_RD1) ? AW'(32'(r_f1) * MAX_CHANNELS + rd_chan)
                                        : AW'(32'(r_f0) * MAX_CHANNELS + rd_chan);
    assign wr_addr = AW'(32'(i_frame_index) * MAX_CHANNELS + 32'(i_channel_index));
    assign wr_en   = in_acc && (i_func == FUNC_WRITE)
                     && (32'(i_frame_index) < MAX_FRAMES)
                     && (32'(i_channel_index) < MAX_CHANNELS);
    assign diff    = 17'(signed'(r_rdata)) - 17'(signed'(r_v0));

    // Write and read the store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_write_value;
        end
        r_rdata <= mem[rd_addr];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && start) n_state = S_MUL1;
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_LOC;
            S_LOC:  n_state = S_RD0;
            S_RD0:  n_state = r_ok ? S_RD1 : S_EMIT;
            S_RD1:  n_state = S_MULT;
            S_MULT: n_state = S_EMIT;
            S_EMIT: begin
                if (slot_free) begin
                    if (is_last) n_state = S_IDLE;
                    else         n_state = r_ok ? S_RD0 : S_EMIT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_cur           <= '0;
            r_ok            <= 1'b0;
            r_o_valid       <= 1'b0;
            r_frame_count   <= '0;
            r_channel_count <= '0;
            r_inv_duration  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FRAME_COUNT:   r_frame_count   <= i_cfg_data[9:0];
                    CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[6:0];
                    CFG_INV_DURATION:  r_inv_duration  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_IDLE && in_acc) begin
                r_cur <= '0;
            end
            if (r_state == S_LOC) begin
                r_ok <= (nf != '0) && (r_inv_duration != '0)
                        && ((r_func == FUNC_ALL) || (32'(r_ch) < 32'(nc)));
            end
            // load the result beat, or drop the taken one
            if (r_state == S_EMIT && slot_free) begin
                r_o_valid <= 1'b1;
                if (!is_last) r_cur <= r_cur + CW'(1);
            end else if (out_acc) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc) begin
            r_func <= i_func;
            r_ch   <= i_channel_index;
            r_time <= i_sample_time;
        end
        // clamp normalized time, then scale by the last frame index
        if (r_state == S_MUL1) begin
            r_u <= (u_full > 64'(U_ONE)) ? U_ONE : u_full[U_W-1:0];
        end
        if (r_state == S_MUL2) begin
            r_p <= PW'(r_u) * PW'(nfm1);
        end
        if (r_state == S_LOC) begin
            r_f0    <= FW'(f0_cl);
            r_f1    <= FW'(f1_nx);
            r_alpha <= r_p[U_FRAC-1:U_FRAC-16];
        end
        if (r_state == S_RD1) begin
            r_v0 <= r_rdata;
        end
        if (r_state == S_MULT) begin
            r_prod <= 34'(diff) * 34'(signed'({1'b0, r_alpha}));
        end
        if (r_state == S_EMIT && slot_free) begin
            r_o_channel   <= (r_func == FUNC_ONE) ? r_ch : 6'(r_cur);
            r_o_value     <= r_ok ? signed'(r_v0 + r_prod[31:16]) : '0;
            r_o_out_valid <= r_ok;
            r_o_last      <= is_last;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_out_channel = r_o_channel;
    assign o_out_value   = r_o_value;
    assign o_out_valid   = r_o_out_valid;
    assign o_out_last    = r_o_last;

endmodule

// ===== hw/rtl/kcls_checker.sv =====
// Port-level checker for the keyframe curve sampler, with its bind.
// Depends on kcls_pkg and keyframe_curve_lerp_sampler.
`timescale 1ns / 1ps

module kcls_port_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input kcls_pkg::t_func      i_func,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic signed [15:0]   o_out_value,
    input logic                 o_out_valid
);
    import kcls_pkg::*;

    // A write or unused code leaves the block free for the next beat
    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_func == FUNC_WRITE || i_func == FUNC_RSVD))
        |=> !o_stall)
        else $error("block busy after a write beat");

    // A sample-one always starts work
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_func == FUNC_ONE) |=> o_stall)
        else $error("sample-one beat did not start work");

    // An invalid result carries zero
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out_valid) |-> (o_out_value == '0))
        else $error("invalid result with nonzero value");

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_value)))
        else $error("stalled result beat changed");

endmodule

bind keyframe_curve_lerp_sampler kcls_port_checker u_kcls_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_func      (i_func),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_out_value (o_out_value),
    .o_out_valid (o_out_valid)
);

// ===== test/kcls_checker.sv =====
// Result checker for the keyframe curve sampler: mirrors register and store
// writes, predicts every result beat and compares it against the block output.
// Depends on kcls_pkg.
`timescale 1ns / 1ps

module kcls_checker #(
    parameter int MAX_FRAMES   = 512,
    parameter int MAX_CHANNELS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration port, as driven into the block
    input  logic               i_cfg_we,
    input  kcls_pkg::t_cfg_idx i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    // input channel
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  kcls_pkg::t_func    i_func,
    input  logic [8:0]         i_frame_index,
    input  logic [5:0]         i_channel_index,
    input  logic signed [15:0] i_write_value,
    input  logic [31:0]        i_sample_time,
    // result channel
    input  logic               i_res_valid,
    input  logic               i_res_stall,
    input  logic [5:0]         i_res_channel,
    input  logic signed [15:0] i_res_value,
    input  logic               i_res_out_valid,
    input  logic               i_res_last,
    // status for the top
    output int                 o_errors,
    output int                 o_pending
);
    import kcls_pkg::*;

    localparam int MAX_REPORTS = 200;

    typedef struct packed {
        logic [5:0] channel;
        t_value     value;
        logic       valid;
        logic       last;
    } curve_res_t;

    curve_res_t  expected_q [$];
    curve_res_t  want;
    logic [15:0] curve_mem [0:MAX_FRAMES*MAX_CHANNELS-1];
    logic [9:0]  frame_cnt;
    logic [6:0]  chan_cnt;
    logic [31:0] inv_dur;
    int          errors = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    // Map a time onto floor frame, next frame and 16-bit fraction.
    // Returns 0 when there are no frames or no duration.
    function automatic bit find_span(input logic [31:0] t, output int unsigned f0,
                                     output int unsigned f1, output logic [15:0] frac);
        int unsigned nf;
        logic [63:0] u;
        logic [63:0] p;
        nf   = (frame_cnt > MAX_FRAMES) ? MAX_FRAMES : frame_cnt;
        f0   = 0;
        f1   = 0;
        frac = '0;
        if (nf == 0 || inv_dur == 0) begin
            return 1'b0;
        end
        u = {32'd0, t} * {32'd0, inv_dur};
        if (u > 64'(U_ONE)) begin
            u = 64'(U_ONE);
        end
        p  = u * 64'(nf - 1);
        f0 = int'(p >> U_FRAC);
        if (f0 > nf - 1) begin
            f0 = nf - 1;
        end
        f1   = (f0 + 1 < nf) ? f0 + 1 : nf - 1;
        frac = p[U_FRAC-1 -: 16];
        return 1'b1;
    endfunction

    // Linear blend between two stored values, step floored toward minus infinity
    function automatic t_value blend(input int unsigned f0, input int unsigned f1,
                                     input int unsigned ch, input logic [15:0] frac);
        longint v0;
        longint v1;
        longint prod;
        v0   = longint'($signed(curve_mem[f0 * MAX_CHANNELS + ch]));
        v1   = longint'($signed(curve_mem[f1 * MAX_CHANNELS + ch]));
        prod = (v1 - v0) * longint'({48'd0, frac});
        return t_value'(v0 + (prod >>> 16));
    endfunction

    // Update the store or queue the results of one input beat
    task automatic predict_beat();
        int unsigned nc;
        int unsigned f0;
        int unsigned f1;
        logic [15:0] frac;
        bit          ok;
        curve_res_t  res;
        nc = (chan_cnt > MAX_CHANNELS) ? MAX_CHANNELS : chan_cnt;
        case (i_func)
            FUNC_WRITE: begin
                curve_mem[i_frame_index * MAX_CHANNELS + i_channel_index] = i_write_value;
            end
            FUNC_ONE: begin
                ok = (i_channel_index < nc) && find_span(i_sample_time, f0, f1, frac);
                res.channel = i_channel_index;
                res.value   = ok ? blend(f0, f1, i_channel_index, frac) : '0;
                res.valid   = ok;
                res.last    = 1'b1;
                expected_q.push_back(res);
            end
            FUNC_ALL: begin
                if (nc != 0) begin
                    ok = find_span(i_sample_time, f0, f1, frac);
                    for (int unsigned c = 0; c < nc; c++) begin
                        res.channel = c[5:0];
                        res.value   = ok ? blend(f0, f1, c, frac) : '0;
                        res.valid   = ok;
                        res.last    = (c + 1 == nc);
                        expected_q.push_back(res);
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_cnt = '0;
            chan_cnt  = '0;
            inv_dur   = '0;
            expected_q.delete();
        end else begin
            // mirror register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_COUNT:   frame_cnt = i_cfg_data[9:0];
                    CFG_CHANNEL_COUNT: chan_cnt  = i_cfg_data[6:0];
                    CFG_INV_DURATION:  inv_dur   = i_cfg_data;
                    default: ;
                endcase
            end
            // predict on every input beat
            if (i_in_valid && !i_in_stall) begin
                predict_beat();
            end
            // compare every result beat against the oldest prediction
            if (i_res_valid && !i_res_stall) begin
                if (expected_q.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("%0t: unexpected result: ch=%0d value=%0d valid=%0b last=%0b",
                                 $time, i_res_channel, i_res_value, i_res_out_valid,
                                 i_res_last);
                    end
                end else begin
                    want = expected_q.pop_front();
                    if (i_res_channel !== want.channel || i_res_value !== want.value ||
                        i_res_out_valid !== want.valid || i_res_last !== want.last) begin
                        errors++;
                        if (errors <= MAX_REPORTS) begin
                            $display("%0t: mismatch: expected ch=%0d value=%0d valid=%0b last=%0b",
                                     $time, want.channel, want.value, want.valid, want.last);
                            $display("%0t:           actual   ch=%0d value=%0d valid=%0b last=%0b",
                                     $time, i_res_channel, i_res_value, i_res_out_valid,
                                     i_res_last);
                        end
                    end
                end
            end
        end
        o_errors  <= errors;
        o_pending <= expected_q.size();
    end

endmodule

// ===== test/testbench.sv =====
// Top of the keyframe curve sampler testbench: clock, reset, stimulus and verdict.
// Depends on kcls_pkg, keyframe_curve_lerp_sampler and kcls_checker.
`timescale 1ns / 1ps

module testbench;
    import kcls_pkg::*;

    localparam int MAX_FRAMES   = 512;
    localparam int MAX_CHANNELS = 64;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 1_000_000;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_cfg_we        = 1'b0;
    t_cfg_idx           i_cfg_index     = CFG_FRAME_COUNT;
    logic [31:0]        i_cfg_data      = '0;
    logic               i_valid         = 1'b0;
    logic               o_stall;
    t_func              i_func          = FUNC_WRITE;
    logic [8:0]         i_frame_index   = '0;
    logic [5:0]         i_channel_index = '0;
    logic signed [15:0] i_write_value   = '0;
    logic [31:0]        i_sample_time   = '0;
    logic               o_valid;
    logic               i_stall         = 1'b0;
    logic [5:0]         o_out_channel;
    logic signed [15:0] o_out_value;
    logic               o_out_valid;
    logic               o_out_last;

    int          errors;
    int          pending;
    int          idle_pct    = 8;
    int          stall_pct   = 8;
    int unsigned cycle_count = 0;
    int unsigned cur_frames  = 0;
    int unsigned cur_chans   = 0;
    logic [31:0] cur_inv     = '0;
    // store entries written since reset; only these may ever be read
    bit          written [0:MAX_FRAMES*MAX_CHANNELS-1];

    keyframe_curve_lerp_sampler #(
        .MAX_FRAMES   (MAX_FRAMES),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_func          (i_func),
        .i_frame_index   (i_frame_index),
        .i_channel_index (i_channel_index),
        .i_write_value   (i_write_value),
        .i_sample_time   (i_sample_time),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_channel   (o_out_channel),
        .o_out_value     (o_out_value),
        .o_out_valid     (o_out_valid),
        .o_out_last      (o_out_last)
    );

    kcls_checker #(
        .MAX_FRAMES   (MAX_FRAMES),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_func          (i_func),
        .i_frame_index   (i_frame_index),
        .i_channel_index (i_channel_index),
        .i_write_value   (i_write_value),
        .i_sample_time   (i_sample_time),
        .i_res_valid     (o_valid),
        .i_res_stall     (i_stall),
        .i_res_channel   (o_out_channel),
        .i_res_value     (o_out_value),
        .i_res_out_valid (o_out_valid),
        .i_res_last      (o_out_last),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stall the result channel at random
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Aim most times inside the clip, some at its end and some far past it
    function automatic logic [31:0] pick_time(input logic [31:0] inv);
        longint unsigned span;
        span = (inv == 0) ? 64'hFFFF_FFFF : ((64'd1 << 40) / inv);
        if (span > 64'hFFFF_FFFF) begin
            span = 64'hFFFF_FFFF;
        end
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return $urandom;
            2:       return span[31:0];
            3:       return (span[31:0] == 32'hFFFF_FFFF) ? span[31:0] : span[31:0] + 1;
            default: return $urandom_range(span[31:0], 0);
        endcase
    endfunction

    // Drive one beat, with random idle cycles ahead of it, and hold it until taken
    task automatic send_item(input t_func fn, input logic [8:0] fr, input logic [5:0] ch,
                             input logic [15:0] val, input logic [31:0] t);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_func          <= fn;
        i_frame_index   <= fr;
        i_channel_index <= ch;
        i_write_value   <= val;
        i_sample_time   <= t;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        if (fn == FUNC_WRITE) begin
            written[fr * MAX_CHANNELS + ch] = 1'b1;
        end
    endtask

    // Drop valid, wait for every predicted result, then let the block settle
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all three registers while the block is idle
    task automatic set_config(input int unsigned nf, input int unsigned nc,
                              input logic [31:0] inv);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FRAME_COUNT;
        i_cfg_data  <= 32'(nf);
        @(posedge i_clk);
        i_cfg_index <= CFG_CHANNEL_COUNT;
        i_cfg_data  <= 32'(nc);
        @(posedge i_clk);
        i_cfg_index <= CFG_INV_DURATION;
        i_cfg_data  <= inv;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_frames = nf;
        cur_chans  = nc;
        cur_inv    = inv;
    endtask

    // Load every entry in use that has not been written yet
    task automatic fill_region();
        for (int f = 0; f < cur_frames && f < MAX_FRAMES; f++) begin
            for (int c = 0; c < cur_chans && c < MAX_CHANNELS; c++) begin
                if (!written[f * MAX_CHANNELS + c]) begin
                    send_item(FUNC_WRITE, f[8:0], c[5:0], pick_value(), $urandom);
                end
            end
        end
    endtask

    // Mix of writes, samples and ignored codes; ignored codes are not counted
    task automatic run_random(input int n);
        int          done_items;
        int unsigned pick;
        logic [5:0]  ch;
        done_items = 0;
        while (done_items < n) begin
            pick = $urandom_range(0, 99);
            if (cur_chans > 0 && $urandom_range(0, 9) != 0) begin
                ch = 6'($urandom_range(cur_chans - 1, 0));
            end else begin
                ch = 6'($urandom);
            end
            if (pick < 30) begin
                send_item(FUNC_WRITE, 9'($urandom), 6'($urandom), pick_value(), $urandom);
            end else if (pick < 34) begin
                send_item(FUNC_RSVD, 9'($urandom), 6'($urandom), 16'($urandom), $urandom);
            end else if (pick < 82) begin
                send_item(FUNC_ONE, 9'($urandom), ch, 16'($urandom), pick_time(cur_inv));
            end else begin
                send_item(FUNC_ALL, 9'($urandom), 6'($urandom), 16'($urandom),
                          pick_time(cur_inv));
            end
            if (pick < 30 || pick >= 34) begin
                done_items++;
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // unconfigured after reset: invalid single result, no sample-all results
        send_item(FUNC_ONE, '0, '0, '0, '0);
        send_item(FUNC_ALL, '0, '0, '0, 32'hFFFF_FFFF);
        send_item(FUNC_RSVD, 9'h1FF, 6'h3F, 16'h7FFF, 32'hFFFF_FFFF);

        // four frames, three channels, one-second clip
        set_config(4, 3, 32'h0100_0000);
        // full-swing steps on channel 0
        send_item(FUNC_WRITE, 9'd0, 6'd0, 16'h7FFF, '0);
        send_item(FUNC_WRITE, 9'd1, 6'd0, 16'h8000, '0);
        send_item(FUNC_WRITE, 9'd2, 6'd0, 16'h7FFF, '0);
        send_item(FUNC_WRITE, 9'd3, 6'd0, 16'h8000, '0);
        fill_region();
        send_item(FUNC_ONE, '0, 6'd0, '0, 32'h0000_0000);
        send_item(FUNC_ONE, '0, 6'd0, '0, 32'h0000_8000);
        send_item(FUNC_ONE, '0, 6'd0, '0, 32'h0000_5555);
        send_item(FUNC_ONE, '0, 6'd1, '0, 32'h0001_0000);
        send_item(FUNC_ONE, '0, 6'd2, '0, 32'hFFFF_FFFF);
        // channel outside the channels in use
        send_item(FUNC_ONE, '0, 6'd3, '0, 32'h0000_8000);
        send_item(FUNC_ONE, '0, 6'd63, '0, 32'h0000_8000);
        send_item(FUNC_ALL, '0, '0, '0, 32'h0000_2AAA);

        // single frame: next frame is capped to the same frame
        set_config(1, 3, 32'h0100_0000);
        send_item(FUNC_ONE, '0, 6'd2, '0, 32'h0000_8000);
        send_item(FUNC_ALL, '0, '0, '0, 32'h0000_C000);

        // zero reciprocal: no valid duration
        set_config(4, 3, '0);
        send_item(FUNC_ONE, '0, 6'd1, '0, 32'h0000_8000);
        send_item(FUNC_ALL, '0, '0, '0, 32'h0000_8000);

        // no frames, largest reciprocal
        set_config(0, 3, 32'hFFFF_FFFF);
        send_item(FUNC_ONE, '0, 6'd0, '0, 32'h0000_0001);
        send_item(FUNC_ALL, '0, '0, '0, 32'h0000_0001);

        // two frames over every channel
        set_config(2, MAX_CHANNELS, $urandom | 32'h1);
        fill_region();
        run_random(50);

        // two frames, one channel, largest reciprocal
        set_config(2, 1, 32'hFFFF_FFFF);
        fill_region();
        run_random(40);

        // long stretch with no idle or stall cycles
        idle_pct  = 0;
        stall_pct = 0;
        set_config(13, 5, $urandom_range(1 << 26, 1 << 16));
        fill_region();
        run_random(40);
        idle_pct  = 8;
        stall_pct = 8;

        // all channels again, with a full drain halfway through
        set_config(2, MAX_CHANNELS, $urandom | 32'h1);
        fill_region();
        run_random(20);
        wait_drained();
        run_random(20);

        repeat (3) begin
            set_config($urandom_range(8, 1), $urandom_range(6, 1), $urandom | 32'h1);
            fill_region();
            run_random(12);
        end

        wait_drained();
        if (errors == 0 && pending == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
